FILE: hdl/defect_pixel_correction_defines.svh
// assertion macros for the defect pixel correction block
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef DEFECT_PIXEL_CORRECTION_DEFINES_SVH
`define DEFECT_PIXEL_CORRECTION_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_CHECK,
    ST_DIV,
    ST_OWN,
    ST_OWN_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_CORRECT = 1'b1
  } op_e;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  // largest chebyshev ring searched
  localparam logic [1:0] MAX_RADIUS = 2'd3;

  localparam int unsigned OFS_COUNT = 52;

  typedef struct packed {
    logic signed [2:0] dx;
    logic signed [2:0] dy;
  } offset_t;

  // cross first, then rings of radius 1, 2 and 3
  localparam offset_t OFS_TABLE [OFS_COUNT] = '{
    // cross
    '{-3'sd1,  3'sd0}, '{ 3'sd1,  3'sd0}, '{ 3'sd0, -3'sd1}, '{ 3'sd0,  3'sd1},
    // ring 1
    '{-3'sd1, -3'sd1}, '{ 3'sd0, -3'sd1}, '{ 3'sd1, -3'sd1},
    '{-3'sd1,  3'sd0}, '{ 3'sd1,  3'sd0},
    '{-3'sd1,  3'sd1}, '{ 3'sd0,  3'sd1}, '{ 3'sd1,  3'sd1},
    // ring 2
    '{-3'sd2, -3'sd2}, '{-3'sd1, -3'sd2}, '{ 3'sd0, -3'sd2}, '{ 3'sd1, -3'sd2},
    '{ 3'sd2, -3'sd2},
    '{-3'sd2, -3'sd1}, '{ 3'sd2, -3'sd1}, '{-3'sd2,  3'sd0}, '{ 3'sd2,  3'sd0},
    '{-3'sd2,  3'sd1}, '{ 3'sd2,  3'sd1},
    '{-3'sd2,  3'sd2}, '{-3'sd1,  3'sd2}, '{ 3'sd0,  3'sd2}, '{ 3'sd1,  3'sd2},
    '{ 3'sd2,  3'sd2},
    // ring 3
    '{-3'sd3, -3'sd3}, '{-3'sd2, -3'sd3}, '{-3'sd1, -3'sd3}, '{ 3'sd0, -3'sd3},
    '{ 3'sd1, -3'sd3}, '{ 3'sd2, -3'sd3}, '{ 3'sd3, -3'sd3},
    '{-3'sd3, -3'sd2}, '{ 3'sd3, -3'sd2}, '{-3'sd3, -3'sd1}, '{ 3'sd3, -3'sd1},
    '{-3'sd3,  3'sd0}, '{ 3'sd3,  3'sd0}, '{-3'sd3,  3'sd1}, '{ 3'sd3,  3'sd1},
    '{-3'sd3,  3'sd2}, '{ 3'sd3,  3'sd2},
    '{-3'sd3,  3'sd3}, '{-3'sd2,  3'sd3}, '{-3'sd1,  3'sd3}, '{ 3'sd0,  3'sd3},
    '{ 3'sd1,  3'sd3}, '{ 3'sd2,  3'sd3}, '{ 3'sd3,  3'sd3}
  };

  // index of the last table entry of a search phase
  function automatic logic [5:0] phase_last(input logic [1:0] phase);
    logic [5:0] last;
    case (phase)
      2'd0:    last = 6'd3;
      2'd1:    last = 6'd11;
      2'd2:    last = 6'd27;
      default: last = 6'd51;
    endcase
    return last;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/defect_pixel_correction.sv
// defect pixel correction: frame store with neighbour average of good pixels
// write request: busy stays low, no result, one write per cycle while not busy
// correct request: result strobe in the cycle after accept when out of frame; otherwise each
//   search phase reads its neighbours until one finds a good pixel, then a divider averages them
//   (own pixel if none in any ring); busy drops in the cycle after the strobe
// reset clears control and size registers (256 x 256), not the pixel memory; no result stall
`timescale 1ns / 1ps
`default_nettype none
`include "defect_pixel_correction_defines.svh"

module defect_pixel_correction #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [8:0]  cfg_wdata_i,
  // request side
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation_i,
  input  wire logic [7:0]  col_i,
  input  wire logic [7:0]  row_i,
  input  wire logic [15:0] value_i,
  input  wire logic        defect_i,
  // result side
  output logic             result_valid_o,
  output logic [15:0]      corrected_value_o,
  output logic [4:0]       neighbour_count_o,
  output logic             out_of_range_o
);
  import dpc_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  // sum of up to 24 pixels plus half the count
  localparam int unsigned SW    = PIXEL_BITS + 5;
  localparam int unsigned STW   = $clog2(SW);
  // frame size clamp; the size registers never exceed 511
  localparam logic [8:0]  W_CAP = 9'(MAX_WIDTH > 511 ? 511 : MAX_WIDTH);
  localparam logic [8:0]  H_CAP = 9'(MAX_HEIGHT > 511 ? 511 : MAX_HEIGHT);

  state_e state_q, state_d;

  logic [8:0] img_w_q, img_h_q;
  logic [8:0] frame_w, frame_h;

  logic [7:0] col_q, row_q;
  logic [5:0] idx_q, idx_d;
  logic [1:0] phase_q, phase_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [4:0] cnt_q, cnt_d;
  logic take_q;
  logic [PIXEL_BITS:0] rd_q;

  // divider: dividend shifts out the top while quotient bits shift in
  logic [SW-1:0] div_q, div_d;
  logic [4:0] rem_q, rem_d;
  logic [STW-1:0] step_q, step_d;
  logic [5:0] trial;
  logic qbit;

  logic [PIXEL_BITS-1:0] res_val_q, res_val_d;
  logic [4:0] res_cnt_q, res_cnt_d;
  logic res_oor_q, res_oor_d;

  logic accept;
  logic in_inside;
  logic [AW-1:0] in_addr, ctr_addr, nb_addr, rd_addr;
  offset_t ofs;
  logic signed [9:0] nb_col, nb_row;
  logic nb_inside;
  logic issue;
  logic mem_we;
  logic [PIXEL_BITS+15:0] wr_ext;
  logic [PIXEL_BITS+15:0] res_ext;
  logic [5:0] last_idx;

  logic [PIXEL_BITS:0] pix_mem [DEPTH];

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 9'd256;
      img_h_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  img_w_q <= cfg_wdata_i;
        REG_IMAGE_HEIGHT: img_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign frame_w = (img_w_q < W_CAP) ? img_w_q : W_CAP;
  assign frame_h = (img_h_q < H_CAP) ? img_h_q : H_CAP;

  assign accept    = start && !busy;
  assign in_inside = ({1'b0, col_i} < frame_w) && ({1'b0, row_i} < frame_h);

  // row-major addressing with a fixed stride of MAX_WIDTH
  assign in_addr  = AW'(row_i) * AW'(MAX_WIDTH) + AW'(col_i);
  assign ctr_addr = AW'(row_q) * AW'(MAX_WIDTH) + AW'(col_q);

  // neighbour coordinate for the current table entry
  assign ofs       = OFS_TABLE[idx_q];
  assign nb_col    = $signed({2'b00, col_q}) + 10'(ofs.dx);
  assign nb_row    = $signed({2'b00, row_q}) + 10'(ofs.dy);
  assign nb_inside = !nb_col[9] && !nb_row[9]
                     && (nb_col[8:0] < frame_w) && (nb_row[8:0] < frame_h);
  assign nb_addr   = AW'(nb_row[8:0]) * AW'(MAX_WIDTH) + AW'(nb_col[8:0]);

  assign rd_addr  = (state_q == ST_OWN) ? ctr_addr : nb_addr;
  assign issue    = (state_q == ST_SCAN) && nb_inside;
  assign mem_we   = accept && (operation_i == OP_WRITE) && in_inside;
  assign wr_ext   = {{PIXEL_BITS{1'b0}}, value_i};
  assign last_idx = phase_last(phase_q);

  // frame store: defect bit on top of the pixel
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pix_mem[in_addr] <= {defect_i, wr_ext[PIXEL_BITS-1:0]};
    end
    rd_q <= pix_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_CORRECT)) begin
          state_d = in_inside ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (idx_q == last_idx) begin
          state_d = ST_WAIT;
        end
      end
      // last read of the phase lands in the accumulator
      ST_WAIT: state_d = ST_CHECK;
      ST_CHECK: begin
        if (cnt_q != 5'd0) begin
          state_d = ST_DIV;
        end else if (phase_q == MAX_RADIUS) begin
          state_d = ST_OWN;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_DIV: begin
        if (step_q == STW'(SW - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_OWN:      state_d = ST_OWN_WAIT;
      ST_OWN_WAIT: state_d = ST_DONE;
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // restoring divide step
  assign trial = {rem_q, div_q[SW-1]};
  assign qbit  = (trial >= {1'b0, cnt_q});

  // datapath
  always_comb begin
    idx_d     = idx_q;
    phase_d   = phase_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    div_d     = div_q;
    rem_d     = rem_q;
    step_d    = step_q;
    res_val_d = res_val_q;
    res_cnt_d = res_cnt_q;
    res_oor_d = res_oor_q;

    // in the cycle after the read issue
    if (take_q && !rd_q[PIXEL_BITS]) begin
      sum_d = sum_q + SW'(rd_q[PIXEL_BITS-1:0]);
      cnt_d = cnt_q + 5'd1;
    end

    case (state_q)
      ST_IDLE: begin
        idx_d     = 6'd0;
        phase_d   = 2'd0;
        sum_d     = '0;
        cnt_d     = 5'd0;
        res_val_d = '0;
        res_cnt_d = 5'd0;
        res_oor_d = !in_inside;
      end
      ST_SCAN: begin
        if (idx_q != last_idx) begin
          idx_d = idx_q + 6'd1;
        end
      end
      ST_CHECK: begin
        if (cnt_q != 5'd0) begin
          // round to nearest, ties up
          div_d  = sum_q + SW'(cnt_q[4:1]);
          rem_d  = 5'd0;
          step_d = '0;
        end else if (phase_q != MAX_RADIUS) begin
          phase_d = phase_q + 2'd1;
          idx_d   = idx_q + 6'd1;
        end
      end
      ST_DIV: begin
        rem_d  = qbit ? 5'(trial - {1'b0, cnt_q}) : trial[4:0];
        div_d  = {div_q[SW-2:0], qbit};
        step_d = step_q + STW'(1);
        if (step_q == STW'(SW - 1)) begin
          res_val_d = div_d[PIXEL_BITS-1:0];
          res_cnt_d = cnt_q;
        end
      end
      ST_OWN_WAIT: begin
        res_val_d = rd_q[PIXEL_BITS-1:0];
        res_cnt_d = 5'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      take_q  <= 1'b0;
      idx_q   <= 6'd0;
      phase_q <= 2'd0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      take_q  <= issue;
      idx_q   <= idx_d;
      phase_q <= phase_d;
      step_q  <= step_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= col_i;
      row_q <= row_i;
    end
    sum_q     <= sum_d;
    cnt_q     <= cnt_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    res_val_q <= res_val_d;
    res_cnt_q <= res_cnt_d;
    res_oor_q <= res_oor_d;
  end

  assign res_ext = {16'd0, res_val_q};

  // outputs
  always_comb begin
    busy              = (state_q != ST_IDLE);
    result_valid_o    = (state_q == ST_DONE);
    corrected_value_o = res_ext[15:0];
    neighbour_count_o = res_cnt_q;
    out_of_range_o    = res_oor_q;
  end

  `DPC_ASSERT_NOW(a_strobe_busy, result_valid_o, busy, "result strobe while idle")
  `DPC_ASSERT_NEXT(a_correct_busy, start && !busy && operation_i == OP_CORRECT, busy,
                   "correct request did not start")
  `DPC_ASSERT_NEXT(a_write_idle, start && !busy && operation_i == OP_WRITE, !busy,
                   "write request left block busy")
  `DPC_ASSERT_NOW(a_oor_zero, result_valid_o && out_of_range_o,
                  corrected_value_o == 16'd0 && neighbour_count_o == 5'd0,
                  "out of frame result not cleared")
  `DPC_ASSERT_NOW(a_count_max, result_valid_o, neighbour_count_o <= 5'd24,
                  "neighbour count above ring size")

endmodule

`default_nettype wire
